// ----- rtl/rhe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rhe_pkg;
	localparam int LEVELS = 256;

	// command codes
	localparam logic CMD_COUNT = 1'b0;
	localparam logic CMD_REMAP = 1'b1;

	// queued word between front and back
	typedef struct packed {
		logic cmd;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic last;
	} rhe_word_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_BUILD, ST_REMAP, ST_ACC
	} rhe_state_t;
endpackage
`default_nettype wire

// ----- rtl/rhe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhe_front import rhe_pkg::*; #(
	parameter int DEPTH_BITS = 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire rhe_word_t in_word,
	output logic q_valid,
	output rhe_word_t q_word,
	input  wire logic q_pop
);
	localparam int DEPTH = 1 << DEPTH_BITS;
	rhe_word_t fifo_q [DEPTH];
	logic [DEPTH_BITS-1:0] wr_q, rd_q;
	logic [DEPTH_BITS:0] cnt_q;
	logic push;

	assign busy = (cnt_q == DEPTH[DEPTH_BITS:0]);
	assign push = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_word = fifo_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_word;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{DEPTH_BITS{1'b0}}, push} - {{DEPTH_BITS{1'b0}}, q_pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rhe_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle; quotient saturates at 255
module rhe_divider #(
	parameter int NB = 22
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic [NB+9:0] num,
	input  wire logic [NB:0] den,
	output logic done,
	output logic [7:0] quo
);
	localparam int W = NB + 10;
	localparam int CB = $clog2(W + 1);
	logic [W-1:0] num_q, quo_q;
	logic [NB+1:0] rem_q;
	logic [NB:0] den_q;
	logic [CB-1:0] cnt_q;
	logic run_q;
	logic [NB+1:0] trial;

	assign trial = {rem_q[NB:0], num_q[W-1]};
	assign quo = (quo_q > W'(255)) ? 8'd255 : quo_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CB'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rhe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhe_back import rhe_pkg::*; #(
	parameter int NB = 22
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire rhe_word_t q_word,
	output logic q_pop,
	output logic out_valid,
	output logic [7:0] blue_out,
	output logic [7:0] green_out,
	output logic [7:0] red_out,
	output logic last_out
);
	// histograms and maps, one memory per channel
	logic [NB-1:0] hist_b [LEVELS];
	logic [NB-1:0] hist_g [LEVELS];
	logic [NB-1:0] hist_r [LEVELS];
	logic [7:0] map_b [LEVELS];
	logic [7:0] map_g [LEVELS];
	logic [7:0] map_r [LEVELS];

	rhe_state_t st_q, st_d;
	rhe_word_t w_q;
	logic [NB-1:0] total_q;
	logic [8:0] idx_q;
	logic [1:0] ph_q;
	logic [1:0] ch_q;
	logic init_q;
	logic [NB-1:0] hb_q, hg_q, hr_q;
	logic [NB-1:0] cum_b_q, cum_g_q, cum_r_q;
	logic [7:0] mb_q, mg_q, mr_q;
	logic [7:0] rd_b, rd_g, rd_r;
	logic div_go, div_done;
	logic [NB+9:0] div_num;
	logic [NB:0] div_den;
	logic [7:0] div_quo;
	logic [NB-1:0] cum_sel;
	logic full;

	assign full = (total_q == {NB{1'b1}});
	assign q_pop = (st_q == ST_IDLE) && q_valid;

	// histogram read address: level counter while building, else the word
	assign rd_b = (st_q == ST_BUILD) ? idx_q[7:0] : w_q.blue;
	assign rd_g = (st_q == ST_BUILD) ? idx_q[7:0] : w_q.green;
	assign rd_r = (st_q == ST_BUILD) ? idx_q[7:0] : w_q.red;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) st_d = (q_word.cmd == CMD_REMAP) ? ST_REMAP : ST_ACC;
			ST_ACC: if (ph_q == 2'd1) st_d = w_q.last ? ST_BUILD : ST_IDLE;
			ST_REMAP: if (ph_q == 2'd1) st_d = w_q.last ? ST_CLEAR : ST_IDLE;
			ST_BUILD: if (idx_q == 9'd256) st_d = ST_IDLE;
			ST_CLEAR: if (idx_q == 9'd255) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// divider operands: entry = (510*c + N) / (2N)
	always_comb begin
		case (ch_q)
			2'd0: cum_sel = cum_b_q;
			2'd1: cum_sel = cum_g_q;
			default: cum_sel = cum_r_q;
		endcase
		div_num = (NB+10)'(cum_sel) * (NB+10)'(510) + (NB+10)'(total_q);
		div_den = {total_q, 1'b0};
		div_go = (st_q == ST_BUILD) && (ph_q == 2'd1) && (total_q != '0);
	end

	rhe_divider #(.NB(NB)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	// control sequence; reset starts a clearing pass over all memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			total_q <= '0;
			idx_q <= '0;
			ph_q <= '0;
			ch_q <= '0;
			init_q <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					ph_q <= '0;
					idx_q <= '0;
					ch_q <= '0;
				end
				ST_ACC: begin
					ph_q <= (ph_q == 2'd1) ? 2'd0 : ph_q + 1'b1;
					if (ph_q == 2'd1 && !full) total_q <= total_q + 1'b1;
				end
				ST_REMAP: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) out_valid <= 1'b1;
				end
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					total_q <= '0;
					if (idx_q == 9'd255) init_q <= 1'b0;
				end
				ST_BUILD: begin
					// ph 0: read bins, ph 3: accumulate, ph 1: start, ph 2: divide per channel
					case (ph_q)
						2'd0: ph_q <= 2'd3;
						2'd3: ph_q <= 2'd1;
						2'd1: ph_q <= 2'd2;
						default: begin
							if (total_q == '0 || div_done) begin
								if (ch_q == 2'd2) begin
									ch_q <= '0;
									ph_q <= '0;
									idx_q <= idx_q + 1'b1;
								end else begin
									ch_q <= ch_q + 1'b1;
									ph_q <= 2'd1;
								end
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	// datapath and memories
	always_ff @(posedge clk) begin
		if (q_pop) w_q <= q_word;
		hb_q <= hist_b[rd_b];
		hg_q <= hist_g[rd_g];
		hr_q <= hist_r[rd_r];
		mb_q <= map_b[w_q.blue];
		mg_q <= map_g[w_q.green];
		mr_q <= map_r[w_q.red];
		case (st_q)
			ST_IDLE: begin
				cum_b_q <= '0;
				cum_g_q <= '0;
				cum_r_q <= '0;
			end
			ST_ACC: if (ph_q == 2'd1 && !full) begin
				hist_b[w_q.blue] <= hb_q + 1'b1;
				hist_g[w_q.green] <= hg_q + 1'b1;
				hist_r[w_q.red] <= hr_q + 1'b1;
			end
			ST_REMAP: if (ph_q == 2'd1) begin
				blue_out <= mb_q;
				green_out <= mg_q;
				red_out <= mr_q;
				last_out <= w_q.last;
			end
			ST_CLEAR: begin
				hist_b[idx_q[7:0]] <= '0;
				hist_g[idx_q[7:0]] <= '0;
				hist_r[idx_q[7:0]] <= '0;
				// tables are cleared only on the pass after reset
				if (init_q) begin
					map_b[idx_q[7:0]] <= '0;
					map_g[idx_q[7:0]] <= '0;
					map_r[idx_q[7:0]] <= '0;
				end
			end
			ST_BUILD: begin
				if (ph_q == 2'd3) begin
					cum_b_q <= cum_b_q + hb_q;
					cum_g_q <= cum_g_q + hg_q;
					cum_r_q <= cum_r_q + hr_q;
				end
				if (ph_q == 2'd2 && (total_q == '0 || div_done)) begin
					case (ch_q)
						2'd0: map_b[idx_q[7:0]] <= (total_q == '0) ? 8'd0 : div_quo;
						2'd1: map_g[idx_q[7:0]] <= (total_q == '0) ? 8'd0 : div_quo;
						default: map_r[idx_q[7:0]] <= (total_q == '0) ? 8'd0 : div_quo;
					endcase
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/rgb_histogram_equalizer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Per-channel histogram equalizer for 8-bit RGB pixels.
// Input: drive cmd, the levels and last_in with start; a word is taken
// when start is high and busy is low. cmd 0 counts the pixel into three
// 256-bin histograms; cmd 1 remaps it through three tables.
// Output: a remapped pixel appears for one cycle with out_valid high,
// after the word register, the table read register and the output
// register; the receiver cannot stall.
// Pacing: the back end takes a word only while idle and finishes it
// (for a count, a read and a write back of the histogram memories)
// before it takes the next. A two-word queue in front lets the source
// keep writing while the back end works; busy rises once it fills.
// A count-pass word with last_in builds the tables: per level and
// channel one restoring division of COUNT_BITS+10 steps, or a zero
// entry if no pixels were counted. A remap word with last_in clears
// the histograms. Reset starts a pass that clears histograms and
// tables; words wait in the queue meanwhile.
module rgb_histogram_equalizer_top import rhe_pkg::*; #(
	parameter int COUNT_BITS = 22
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic cmd,
	input  wire logic [7:0] blue_in,
	input  wire logic [7:0] green_in,
	input  wire logic [7:0] red_in,
	input  wire logic last_in,
	output logic out_valid,
	output logic [7:0] blue_out,
	output logic [7:0] green_out,
	output logic [7:0] red_out,
	output logic last_out
);
	rhe_word_t in_word, q_word;
	logic q_valid, q_pop;

	assign in_word = '{cmd: cmd, blue: blue_in, green: green_in, red: red_in, last: last_in};

	rhe_front #(.DEPTH_BITS(1)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
	);

	rhe_back #(.NB(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
		.out_valid(out_valid), .blue_out(blue_out), .green_out(green_out),
		.red_out(red_out), .last_out(last_out)
	);
endmodule
`default_nettype wire

// ----- rtl/rhe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic out_valid
);
	// a result strobe never stays high on consecutive cycles
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid) else $error("out_valid held");
	// a result is followed by a gap with out_valid low before the next
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid ##1 !out_valid) else $error("results too close");
	// handshake outputs are always known out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({busy, out_valid})) else $error("unknown handshake");
	// busy comes only from queue filling: needs a taken word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without word");
endmodule
bind rgb_histogram_equalizer_top rhe_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
`default_nettype wire

// ----- tb/sv/rgb_histogram_equalizer_top_tb.sv -----
`timescale 1ns / 1ps
module rgb_histogram_equalizer_top_tb;
	import rhe_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam int TAIL_CYCLES = 64;

	typedef struct {
		bit cmd;
		bit [7:0] blue;
		bit [7:0] green;
		bit [7:0] red;
		bit last;
		bit hold;  // wait for all remapped pixels before sending
	} pixel_word_t;

	typedef struct {
		bit [7:0] blue;
		bit [7:0] green;
		bit [7:0] red;
		bit last;
	} remap_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cmd = 1'b0;
	logic [7:0] blue_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] red_in = '0;
	logic last_in = 1'b0;
	logic busy, out_valid, last_out;
	logic [7:0] blue_out, green_out, red_out;

	pixel_word_t pending_words[$];
	remap_word_t expected_pixels[$];
	pixel_word_t cur_word;
	bit taken = 1'b0;
	int words_sent = 0;
	int total_words = 0;
	int errors = 0;
	int quiet_cycles = 0;

	// predictor state: channel 0 blue, 1 green, 2 red
	int unsigned hist[3][LEVELS];
	bit [7:0] lut[3][LEVELS];
	int unsigned pix_count = 0;

	rgb_histogram_equalizer_top #(.COUNT_BITS(22)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.blue_in(blue_in), .green_in(green_in), .red_in(red_in),
		.last_in(last_in), .out_valid(out_valid), .blue_out(blue_out),
		.green_out(green_out), .red_out(red_out), .last_out(last_out)
	);

	always #2 clk = ~clk;

	task automatic report(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// rebuild the three equalization tables from the histograms
	task automatic build_luts();
		longint unsigned cum, q;
		for (int ch = 0; ch < 3; ch++) begin
			cum = 0;
			for (int v = 0; v < LEVELS; v++) begin
				cum += hist[ch][v];
				if (pix_count == 0) begin
					lut[ch][v] = 8'd0;
				end else begin
					q = (510 * cum + pix_count) / (2 * longint'(pix_count));
					lut[ch][v] = (q > 255) ? 8'd255 : q[7:0];
				end
			end
		end
	endtask

	task automatic equalize_word(input pixel_word_t w);
		remap_word_t r;
		if (w.cmd == CMD_COUNT) begin
			if (pix_count < (1 << 22) - 1) begin
				hist[0][w.blue]++;
				hist[1][w.green]++;
				hist[2][w.red]++;
				pix_count++;
			end
			if (w.last)
				build_luts();
		end else begin
			r.blue = lut[0][w.blue];
			r.green = lut[1][w.green];
			r.red = lut[2][w.red];
			r.last = w.last;
			expected_pixels.push_back(r);
			if (w.last) begin
				foreach (hist[ch, v])
					hist[ch][v] = 0;
				pix_count = 0;
			end
		end
	endtask

	task automatic add_word(input bit c, input bit [7:0] b, input bit [7:0] g,
			input bit [7:0] r, input bit l, input bit h = 1'b0);
		pixel_word_t w;
		w.cmd = c;
		w.blue = b;
		w.green = g;
		w.red = r;
		w.last = l;
		w.hold = h;
		pending_words.push_back(w);
	endtask

	// one frame: counting pass then remap pass, blue and green (count) or blue and red (remap) levels drawn from a window
	task automatic add_frame(input int n_count, input int n_remap);
		int lo, hi;
		lo = $urandom_range(0, 255);
		hi = $urandom_range(lo, 255);
		if ($urandom_range(0, 3) == 0) begin
			lo = 0;
			hi = 255;
		end
		for (int i = 0; i < n_count; i++)
			add_word(CMD_COUNT, 8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
				8'($urandom_range(0, 255)), i == n_count - 1);
		for (int i = 0; i < n_remap; i++)
			add_word(CMD_REMAP, 8'($urandom_range(lo, hi)), 8'($urandom_range(0, 255)),
				8'($urandom_range(lo, hi)), i == n_remap - 1);
	endtask

	// accept words, check remapped pixels, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				equalize_word(cur_word);
				taken = 1'b1;
				quiet_cycles = 0;
			end
			if (out_valid) begin
				quiet_cycles = 0;
				if (expected_pixels.size() == 0) begin
					report("remapped pixel with none expected");
				end else begin
					remap_word_t e;
					e = expected_pixels.pop_front();
					if (blue_out !== e.blue)
						report($sformatf("blue %0d exp %0d", blue_out, e.blue));
					if (green_out !== e.green)
						report($sformatf("green %0d exp %0d", green_out, e.green));
					if (red_out !== e.red)
						report($sformatf("red %0d exp %0d", red_out, e.red));
					if (last_out !== e.last)
						report($sformatf("last %0b exp %0b", last_out, e.last));
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("rgb_histogram_equalizer_top_tb: FAIL");
				$finish;
			end
		end
	end

	// drive words at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			int idle_pct;
			taken = 1'b0;
			idle_pct = (words_sent < total_words / 3) ? 21 :
				(words_sent < 2 * total_words / 3) ? 79 : 0;
			if (pending_words.size() != 0 && !(pending_words[0].hold &&
					expected_pixels.size() != 0) &&
					$urandom_range(0, 99) >= idle_pct) begin
				cur_word = pending_words.pop_front();
				words_sent++;
				cmd <= cur_word.cmd;
				blue_in <= cur_word.blue;
				green_in <= cur_word.green;
				red_in <= cur_word.red;
				last_in <= cur_word.last;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin
		foreach (hist[ch, v]) begin
			hist[ch][v] = 0;
			lut[ch][v] = 8'd0;
		end
		// remap before any build: tables are zero
		add_word(CMD_REMAP, 8'h00, 8'hFF, 8'hA5, 1'b0);
		add_word(CMD_REMAP, 8'hFF, 8'h00, 8'h5A, 1'b1);
		// extremes, then a repeated build on the same histograms
		add_word(CMD_COUNT, 8'h00, 8'hFF, 8'h00, 1'b0);
		add_word(CMD_COUNT, 8'hFF, 8'h00, 8'hFF, 1'b0);
		add_word(CMD_COUNT, 8'h80, 8'h7F, 8'h01, 1'b1);
		add_word(CMD_REMAP, 8'h00, 8'h00, 8'h00, 1'b0);
		add_word(CMD_REMAP, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		add_word(CMD_COUNT, 8'h55, 8'hAA, 8'hFE, 1'b1);
		add_word(CMD_REMAP, 8'h7F, 8'h80, 8'h55, 1'b0);
		add_word(CMD_REMAP, 8'hAA, 8'h01, 8'hFE, 1'b1);
		// single pixel frame, sent after the pipeline drains
		add_word(CMD_COUNT, 8'h33, 8'hCC, 8'h0F, 1'b1, 1'b1);
		add_word(CMD_REMAP, 8'h33, 8'h00, 8'hFF, 1'b1);
		// random frames, some broken with stray commands
		while (pending_words.size() < 1150) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					add_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
						8'($urandom), $urandom_range(0, 3) == 0,
						$urandom_range(0, 15) == 0);
			end else begin
				add_frame($urandom_range(1, 48), $urandom_range(1, 48));
			end
		end
		add_frame(4, 4);
		total_words = pending_words.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || start || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("rgb_histogram_equalizer_top_tb: PASS");
		end else begin
			$display("rgb_histogram_equalizer_top_tb: FAIL");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/rhe_pkg.sv
rtl/rhe_front.sv
rtl/rhe_divider.sv
rtl/rhe_back.sv
rtl/rgb_histogram_equalizer_top.sv
rtl/rhe_checker.sv
tb/sv/rgb_histogram_equalizer_top_tb.sv
